[hw/rtl/sob_pkg.sv]
// Shared constants and types for the Sobel edge magnitude block.
// No dependencies; used by sob_cell and sobel_edge_magnitude_rgb.
`timescale 1ns / 1ps

package sob_pkg;

   localparam int LINE_LENGTH = 256;
   localparam int COL_WIDTH   = $clog2(LINE_LENGTH);
   localparam int PIX_WIDTH   = 8;
   localparam int RGB_SUM_WIDTH = 10;
   localparam int VSUM_WIDTH  = 10;
   localparam int VDIFF_WIDTH = 9;
   localparam int GRAD_WIDTH  = 11;
   localparam int ABS_WIDTH   = 10;
   localparam int MAG_WIDTH   = 11;
   localparam int PROD_WIDTH  = 20;

   // divide by three: floor(x * 683 / 2048) is exact for x up to 765
   localparam logic [RGB_SUM_WIDTH-1:0] GRAY_RECIP = 10'd683;
   localparam int GRAY_SHIFT = 11;

   localparam logic [1:0] LINES_FULL = 2'd2;
   localparam logic [COL_WIDTH-1:0] COL_LAST = COL_WIDTH'(LINE_LENGTH - 1);
   localparam logic [COL_WIDTH-1:0] COL_FIRST_FULL = COL_WIDTH'(2);
   localparam logic [MAG_WIDTH-1:0] MAG_MAX = 11'd2040;

   typedef logic [PIX_WIDTH-1:0] pix_type;

   // one column of the neighbourhood, top to bottom
   typedef struct packed {
      pix_type top;
      pix_type mid;
      pix_type bot;
   } col_type;

   // vertical partials of one column: 1,2,1 weighted sum and bottom minus top
   typedef struct packed {
      logic [VSUM_WIDTH-1:0]         vsum;
      logic signed [VDIFF_WIDTH-1:0] vdiff;
   } vert_type;

   // one line store word: gray two lines back and one line back
   typedef struct packed {
      pix_type upper;
      pix_type middle;
   } line_pair_type;

   localparam int LINE_PAIR_WIDTH = $bits(line_pair_type);

endpackage

[hw/rtl/sob_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sob_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // read during write at the same address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

[hw/rtl/sob_cell.sv]
// One column cell of the 3x3 window: holds a pixel column and its vertical partials.
// Depends on sob_pkg.
`timescale 1ns / 1ps

module sob_cell (
   input  logic            clock,
   input  logic            shift_en,
   input  sob_pkg::col_type  col_in,
   output sob_pkg::col_type  col_out,
   output sob_pkg::vert_type vert_out
);

   sob_pkg::col_type  col_ff;
   sob_pkg::vert_type vert_ff;
   sob_pkg::vert_type vert_in;

   always_comb begin
      vert_in.vsum = {2'b00, col_in.top} + {1'b0, col_in.mid, 1'b0} + {2'b00, col_in.bot};
      vert_in.vdiff = $signed({1'b0, col_in.bot}) - $signed({1'b0, col_in.top});
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff  <= col_in;
         vert_ff <= vert_in;
      end
   end

   assign col_out  = col_ff;
   assign vert_out = vert_ff;

endmodule

[hw/rtl/sobel_edge_magnitude_rgb.sv]
// Top level: gray conversion, line store, column-cell window and gradient stages.
// Depends on sob_pkg, sob_ram and sob_cell.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   req     | req_valid/req_ready, red, green, blue, frame_start | in
//   rsp     | rsp_valid/rsp_ready, magnitude, line_end     | out
//
// One pixel word per clock while req_ready is high. A result passes through
// the line store read, window shift, gradient and magnitude registers.
// Reset clears the column and line counters and the stage valids; the line
// store and window are not cleared and are refilled before they are used.
// Each stage holds on its own when the next is full, so bubbles close up and
// req_ready only falls once every stage is occupied behind a stalled rsp.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_magnitude,
   output logic        rsp_line_end
);

   localparam int CW = sob_pkg::COL_WIDTH;

   // handshake between stages
   logic accept, s1_free, s1_move, s2_free, s2_move, s3_free, out_load;

   // position counters
   logic [CW-1:0] col_ff, col_in, col_now;
   logic [1:0]    lines_ff, lines_in, lines_now;
   logic          emit_now, end_now;

   // gray conversion
   logic [sob_pkg::RGB_SUM_WIDTH-1:0] rgb_sum;
   logic [sob_pkg::PROD_WIDTH-1:0]    gray_prod;
   sob_pkg::pix_type                  gray_now;

   // stage 1: line store read data valid
   logic             s1_valid_ff, s1_valid_in;
   sob_pkg::pix_type s1_gray_ff;
   logic [CW-1:0]    s1_col_ff;
   logic             s1_emit_ff, s1_end_ff;
   logic             byp_valid_ff, byp_valid_in;
   sob_pkg::line_pair_type byp_data_ff;
   sob_pkg::line_pair_type ram_rd, line_rd, line_wr;
   logic [sob_pkg::LINE_PAIR_WIDTH-1:0] ram_rd_bits;

   // stage 2: window cells
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_emit_ff, s2_end_ff;
   sob_pkg::col_type  new_col, col_r, col_c, col_l;
   sob_pkg::vert_type vert_r, vert_c, vert_l;

   // stage 3: gradients
   logic s3_valid_ff, s3_valid_in, s3_end_ff;
   logic signed [sob_pkg::GRAD_WIDTH-1:0] gx_in, gy_in, s3_gx_ff, s3_gy_ff;

   // output register
   logic rsp_valid_ff, rsp_valid_in, rsp_end_ff;
   logic [sob_pkg::ABS_WIDTH-1:0] abs_x, abs_y;
   logic [sob_pkg::MAG_WIDTH-1:0] mag_in, rsp_mag_ff;

   assign out_load  = s3_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s3_free   = !s3_valid_ff || out_load;
   assign s2_move   = s2_valid_ff && s3_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_move   = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && s1_free;

   // frame_start clears the position before this pixel is placed
   always_comb begin
      col_now   = req_frame_start ? '0 : col_ff;
      lines_now = req_frame_start ? 2'd0 : lines_ff;
      emit_now  = (lines_now >= sob_pkg::LINES_FULL) && (col_now >= sob_pkg::COL_FIRST_FULL);
      end_now   = (col_now == sob_pkg::COL_LAST);
      col_in    = col_ff;
      lines_in  = lines_ff;
      if (accept) begin
         if (end_now) begin
            col_in   = '0;
            lines_in = (lines_now < sob_pkg::LINES_FULL) ? lines_now + 2'd1 : lines_now;
         end else begin
            col_in   = col_now + CW'(1);
            lines_in = lines_now;
         end
      end
   end

   always_comb begin
      rgb_sum   = {2'b00, req_red} + {2'b00, req_green} + {2'b00, req_blue};
      gray_prod = sob_pkg::PROD_WIDTH'(rgb_sum) * sob_pkg::PROD_WIDTH'(sob_pkg::GRAY_RECIP);
      gray_now  = gray_prod[sob_pkg::GRAY_SHIFT +: sob_pkg::PIX_WIDTH];
   end

   // line store word: upper takes the old middle, middle takes the new gray
   assign ram_rd  = sob_pkg::line_pair_type'(ram_rd_bits);
   assign line_rd = byp_valid_ff ? byp_data_ff : ram_rd;
   always_comb begin
      line_wr.upper  = line_rd.middle;
      line_wr.middle = s1_gray_ff;
   end
   // a read of the column being written this cycle takes the written word instead
   assign byp_valid_in = s1_move && (col_now == s1_col_ff);

   sob_ram #(
      .WIDTH(sob_pkg::LINE_PAIR_WIDTH),
      .DEPTH(sob_pkg::LINE_LENGTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (s1_move),
      .wr_addr(s1_col_ff),
      .wr_data(line_wr),
      .rd_en  (accept),
      .rd_addr(col_now),
      .rd_data(ram_rd_bits)
   );

   always_comb begin
      new_col.top = line_rd.upper;
      new_col.mid = line_rd.middle;
      new_col.bot = s1_gray_ff;
   end

   // window: right cell takes the new column, columns move leftwards
   sob_cell u_cell_right (
      .clock(clock), .shift_en(s1_move), .col_in(new_col), .col_out(col_r), .vert_out(vert_r)
   );
   sob_cell u_cell_centre (
      .clock(clock), .shift_en(s1_move), .col_in(col_r), .col_out(col_c), .vert_out(vert_c)
   );
   sob_cell u_cell_left (
      .clock(clock), .shift_en(s1_move), .col_in(col_c), .col_out(col_l), .vert_out(vert_l)
   );

   always_comb begin
      gx_in = $signed({1'b0, vert_r.vsum}) - $signed({1'b0, vert_l.vsum});
      gy_in = $signed({{2{vert_l.vdiff[sob_pkg::VDIFF_WIDTH-1]}}, vert_l.vdiff})
            + $signed({vert_c.vdiff[sob_pkg::VDIFF_WIDTH-1], vert_c.vdiff, 1'b0})
            + $signed({{2{vert_r.vdiff[sob_pkg::VDIFF_WIDTH-1]}}, vert_r.vdiff});
   end

   // gradients stay within +-1020, so ten bits hold each absolute value
   always_comb begin
      abs_x  = s3_gx_ff[sob_pkg::GRAD_WIDTH-1] ? sob_pkg::ABS_WIDTH'(-s3_gx_ff)
                                              : sob_pkg::ABS_WIDTH'(s3_gx_ff);
      abs_y  = s3_gy_ff[sob_pkg::GRAD_WIDTH-1] ? sob_pkg::ABS_WIDTH'(-s3_gy_ff)
                                              : sob_pkg::ABS_WIDTH'(s3_gy_ff);
      mag_in = {1'b0, abs_x} + {1'b0, abs_y};
   end

   assign s1_valid_in  = s1_free ? accept : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_move : s2_valid_ff;
   assign s3_valid_in  = s3_free ? (s2_move && s2_emit_ff) : s3_valid_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         lines_ff     <= 2'd0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         lines_ff     <= lines_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            byp_valid_ff <= byp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_gray_ff  <= gray_now;
         s1_col_ff   <= col_now;
         s1_emit_ff  <= emit_now;
         s1_end_ff   <= end_now;
         byp_data_ff <= line_wr;
      end
      if (s1_move) begin
         s2_emit_ff <= s1_emit_ff;
         s2_end_ff  <= s1_end_ff;
      end
      if (s2_move) begin
         s3_gx_ff  <= gx_in;
         s3_gy_ff  <= gy_in;
         s3_end_ff <= s2_end_ff;
      end
      if (out_load) begin
         rsp_mag_ff <= mag_in;
         rsp_end_ff <= s3_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_line_end  = rsp_end_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= sob_pkg::COL_LAST)
      else $error("column counter beyond line length");

   a_lines_sat: assert property (@(posedge clock) disable iff (reset)
      lines_ff <= sob_pkg::LINES_FULL)
      else $error("line count beyond saturation");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start |=> col_ff == CW'(1) && lines_ff == 2'd0)
      else $error("frame start did not restart the position");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mag_ff <= sob_pkg::MAG_MAX)
      else $error("magnitude out of range");

endmodule
